[rtl/sce_pkg.sv]
// Package for the seam cumulative energy block: field widths, reset values
// and the tag carried from the front end to the back end.
// Used by sce_if, sce_front, sce_back and seam_cumulative_energy.
package sce_pkg;

  localparam int ENERGY_W            = 12;
  localparam int WEIGHT_W            = 16;
  localparam int PROD_W              = ENERGY_W + WEIGHT_W;
  localparam int FRAC_SHIFT          = 15;
  localparam int SCALED_W            = 13;
  localparam int SUM_W               = 32;
  localparam int COL_W               = 7;
  localparam int SW_W                = 8;
  localparam int STRIP_WIDTH_RESET   = 50;
  localparam int MAX_STRIP_WIDTH_DEF = 128;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (FRAC_SHIFT - 1);
  localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};

  typedef struct packed {
    logic [SCALED_W-1:0] scaled;
    logic                first;
    logic                at_end;
  } sce_tag_t;

endpackage

[rtl/sce_if.sv]
// Valid/ready channel interfaces for the pixel input and the result output.
// Depends on sce_pkg for the field widths.
interface sce_in_if import sce_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ENERGY_W-1:0] energy;
  logic [WEIGHT_W-1:0] weight;
  logic                first_row;

  modport source (output valid, energy, weight, first_row, input ready);
  modport sink   (input valid, energy, weight, first_row, output ready);
endinterface

interface sce_out_if import sce_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] cumulative;
  logic [COL_W-1:0] column;
  logic             row_end;

  modport source (output valid, cumulative, column, row_end, input ready);
  modport sink   (input valid, cumulative, column, row_end, output ready);
endinterface

[rtl/sce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/sce_queue.sv]
// Small register FIFO between the front and back ends.
// No dependencies.
module sce_queue #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/sce_front.sv]
// Front end: accepts pixels, tracks the column, scales energy by weight.
// Depends on sce_pkg and sce_if.
module sce_front import sce_pkg::*; #(
  parameter int MAX_STRIP_WIDTH = MAX_STRIP_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  sce_in_if.sink                             in_ch,
  input  logic                               cfg_we,
  input  logic [SW_W-1:0]                    cfg_data,
  input  logic                               q_full,
  output logic                               q_push,
  output logic [$clog2(MAX_STRIP_WIDTH)-1:0] q_col,
  output sce_tag_t                           q_tag
);

  localparam int AW       = $clog2(MAX_STRIP_WIDTH);
  localparam int LW       = (AW + 1 > SW_W) ? AW + 1 : SW_W;
  localparam int LAST_RST =
    ((STRIP_WIDTH_RESET > MAX_STRIP_WIDTH) ? MAX_STRIP_WIDTH : STRIP_WIDTH_RESET) - 1;

  logic [AW-1:0]     last_r, last_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [LW-1:0]     w_ext, w_clamp;
  logic [AW-1:0]     col;
  logic              at_end;
  logic [PROD_W-1:0] prod;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    w_ext = LW'(cfg_data);
    priority if (w_ext < LW'(2)) begin
      w_clamp = LW'(2);
    end else if (w_ext > LW'(MAX_STRIP_WIDTH)) begin
      w_clamp = LW'(MAX_STRIP_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    last_nxt = AW'(w_clamp - LW'(1));
  end

  always_comb begin
    col     = (cnt_r > last_r) ? last_r : cnt_r;
    at_end  = (col == last_r);
    cnt_nxt = at_end ? '0 : col + AW'(1);
    prod    = PROD_W'(in_ch.energy) * PROD_W'(in_ch.weight) + ROUND_BIAS;
  end

  assign q_col         = col;
  assign q_tag.scaled  = prod[FRAC_SHIFT +: SCALED_W];
  assign q_tag.first   = in_ch.first_row;
  assign q_tag.at_end  = at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= AW'(LAST_RST);
      cnt_r  <= '0;
    end else if (cfg_we) begin
      last_r <= last_nxt;
      cnt_r  <= '0;
    end else if (q_push) begin
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[rtl/sce_back.sv]
// Back end: picks the best neighbor above, adds with saturation, updates the
// line store and holds the result register. Depends on sce_pkg, sce_if, sce_ram.
module sce_back import sce_pkg::*; #(
  parameter int MAX_STRIP_WIDTH = MAX_STRIP_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               restart,
  input  logic                               q_valid,
  input  logic [$clog2(MAX_STRIP_WIDTH)-1:0] q_col,
  input  sce_tag_t                           q_tag,
  output logic                               q_pop,
  sce_out_if.source                          out_ch
);

  localparam int AW = $clog2(MAX_STRIP_WIDTH);

  logic             fire;
  logic [SUM_W-1:0] rd_data;
  logic [SUM_W-1:0] left_r, up_r, row0_r, row1_r;
  logic             wrap_r;
  logic [SUM_W-1:0] up_c, upr_c, best, scaled_ext, result;
  logic [SUM_W:0]   sum;
  logic             out_valid_r;
  logic [SUM_W-1:0] out_cum_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_end_r;

  assign fire  = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = fire;

  sce_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_STRIP_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (fire),
    .waddr (q_col),
    .wdata (result),
    .re    (fire),
    .raddr (q_col + AW'(2)),
    .rdata (rd_data)
  );

  always_comb begin
    up_c       = wrap_r ? row0_r : up_r;
    upr_c      = wrap_r ? row1_r : rd_data;
    scaled_ext = SUM_W'(q_tag.scaled);
    priority if (q_col == '0) begin
      best = (up_c > upr_c) ? up_c : upr_c;
    end else if (q_tag.at_end) begin
      best = (left_r > up_c) ? left_r : up_c;
    end else if (left_r > up_c) begin
      best = (left_r > upr_c) ? left_r : upr_c;
    end else begin
      best = (up_c > upr_c) ? up_c : upr_c;
    end
    sum = {1'b0, scaled_ext} + {1'b0, best};
    priority if (q_tag.first) begin
      result = scaled_ext;
    end else if (sum[SUM_W]) begin
      result = SUM_MAX;
    end else begin
      result = sum[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      left_r <= up_c;
      up_r   <= upr_c;
      if (q_col == '0) begin
        row0_r <= result;
      end
      if (q_col == AW'(1)) begin
        row1_r <= result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= 1'b1;
    end else if (restart) begin
      wrap_r <= 1'b1;
    end else if (fire) begin
      wrap_r <= q_tag.at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_cum_r <= result;
      out_col_r <= COL_W'(q_col);
      out_end_r <= q_tag.at_end;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cumulative = out_cum_r;
  assign out_ch.column     = out_col_r;
  assign out_ch.row_end    = out_end_r;

endmodule

[rtl/seam_cumulative_energy.sv]
// Seam cumulative energy map: takes pixels in raster order and returns one
// cumulative value per pixel, passing each pixel through the queue and then
// the result register. The rate is one pixel per cycle while the output is not
// stalled and the queue is not full, set by the line store, which is read once
// per pixel two columns ahead while the up-left and up values are held in
// registers. The line store needs no clearing pass after reset. A write of cfg_data restarts the column count at zero.
// Depends on sce_pkg, sce_if, sce_ram, sce_queue, sce_front and sce_back.
module seam_cumulative_energy import sce_pkg::*; #(
  parameter int MAX_STRIP_WIDTH = MAX_STRIP_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  sce_in_if.sink          in_ch,
  sce_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [SW_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_STRIP_WIDTH);
  localparam int TW = $bits(sce_tag_t);
  localparam int QW = AW + TW;

  logic          q_full, q_push, q_valid, q_pop;
  logic [AW-1:0] push_col;
  sce_tag_t      push_tag;
  logic [QW-1:0] head_data;
  logic [AW-1:0] head_col;
  sce_tag_t      head_tag;

  sce_front #(
    .MAX_STRIP_WIDTH (MAX_STRIP_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_col    (push_col),
    .q_tag    (push_tag)
  );

  sce_queue #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  ({push_col, push_tag}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_data)
  );

  assign head_col = head_data[QW-1:TW];
  assign head_tag = sce_tag_t'(head_data[TW-1:0]);

  sce_back #(
    .MAX_STRIP_WIDTH (MAX_STRIP_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_we),
    .q_valid (q_valid),
    .q_col   (head_col),
    .q_tag   (head_tag),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
